### hdl/slj_pkg.sv
// ----------------------------------------------------------------------------
// slj_pkg
// Types, widths, register indexes and pipeline lengths shared by the
// shifted Lennard-Jones pair energy pipeline.
// ----------------------------------------------------------------------------
package slj_pkg;

  localparam int unsigned CFG_W   = 21;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_CORE    = 2'd1;

  localparam logic [CFG_W-1:0] CUTOFF_FACTOR_RST = 21'd163840;
  localparam logic [CFG_W-1:0] SHIFT_CORE_RST    = 21'd65536;

  // 2^(1/6) in Q16.16
  localparam logic [16:0] K_Q16 = 17'd73562;

  // sqrt: one result bit per stage
  localparam int unsigned SQ_IN_W   = 62;
  localparam int unsigned SQ_W      = 63;
  localparam int unsigned ROOT_W    = 31;
  localparam int unsigned SQ_STAGES = 31;

  // divider: one quotient bit per stage
  localparam int unsigned DV_D_W    = 32;
  localparam int unsigned DV_Q_W    = 36;
  localparam int unsigned DV_STAGES = 36;

  // lj term pipeline
  localparam int unsigned TM_STAGES = 12;
  localparam int unsigned TERM_W    = 53;

  // 2^48 / 2^36, remainder after the leading quotient bits of 1/cutoff_factor
  localparam logic [DV_D_W-1:0] G_REM0 = 32'd4096;

  localparam int unsigned SLJ_LATENCY = 4 + SQ_STAGES + 1 + DV_STAGES + TM_STAGES + 1;

  localparam logic signed [47:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] OUT_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic [23:0]        diam_a;
    logic [23:0]        diam_b;
    logic [23:0]        well_depth;
    logic               pair_kind;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] half_energy;
    logic               within_cutoff;
    logic               saturated;
  } out_item_t;

endpackage

### hdl/slj_sqrt.sv
// ----------------------------------------------------------------------------
// slj_sqrt
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module slj_sqrt (
  input  logic                         clk,
  input  logic [slj_pkg::SQ_IN_W-1:0]  rad,
  output logic [slj_pkg::ROOT_W-1:0]   root
);
  import slj_pkg::*;

  logic [SQ_W-1:0] v_r     [SQ_STAGES];
  logic [SQ_W-1:0] res_r   [SQ_STAGES];
  logic [SQ_W-1:0] v_nxt   [SQ_STAGES];
  logic [SQ_W-1:0] res_nxt [SQ_STAGES];

  always_comb begin
    logic [SQ_W-1:0] v_in;
    logic [SQ_W-1:0] res_in;
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        v_in   = {1'b0, rad};
        res_in = '0;
      end else begin
        v_in   = v_r[k-1];
        res_in = res_r[k-1];
      end
      bitv  = SQ_W'(1) << (2 * (SQ_STAGES - 1 - k));
      trial = res_in + bitv;
      if (v_in >= trial) begin
        v_nxt[k]   = v_in - trial;
        res_nxt[k] = (res_in >> 1) + bitv;
      end else begin
        v_nxt[k]   = v_in;
        res_nxt[k] = res_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      v_r[k]   <= v_nxt[k];
      res_r[k] <= res_nxt[k];
    end
  end

  assign root = res_r[SQ_STAGES-1][ROOT_W-1:0];

endmodule

### hdl/slj_div.sv
// ----------------------------------------------------------------------------
// slj_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// supplies the partial remainder left after the leading quotient bits,
// which must be below the divisor.
// ----------------------------------------------------------------------------
module slj_div (
  input  logic                        clk,
  input  logic [slj_pkg::DV_D_W-1:0]  divisor,
  input  logic [slj_pkg::DV_D_W-1:0]  rem_init,
  input  logic [slj_pkg::DV_Q_W-1:0]  num,
  output logic [slj_pkg::DV_Q_W-1:0]  quot
);
  import slj_pkg::*;

  logic [DV_D_W-1:0] d_r      [DV_STAGES];
  logic [DV_D_W-1:0] rem_r    [DV_STAGES];
  logic [DV_Q_W-1:0] nq_r     [DV_STAGES];
  logic [DV_D_W-1:0] rem_nxt  [DV_STAGES];
  logic [DV_Q_W-1:0] nq_nxt   [DV_STAGES];
  logic [DV_D_W-1:0] d_nxt    [DV_STAGES];

  // numerator bits shift out the top while quotient bits shift in below
  always_comb begin
    logic [DV_D_W-1:0] d_in;
    logic [DV_D_W-1:0] rem_in;
    logic [DV_Q_W-1:0] nq_in;
    logic [DV_D_W:0]   t;
    logic [DV_D_W:0]   diff;
    logic              ge;
    for (int k = 0; k < DV_STAGES; k++) begin
      if (k == 0) begin
        d_in   = divisor;
        rem_in = rem_init;
        nq_in  = num;
      end else begin
        d_in   = d_r[k-1];
        rem_in = rem_r[k-1];
        nq_in  = nq_r[k-1];
      end
      t    = {rem_in, nq_in[DV_Q_W-1]};
      diff = t - {1'b0, d_in};
      ge   = (t >= {1'b0, d_in});
      rem_nxt[k] = ge ? diff[DV_D_W-1:0] : t[DV_D_W-1:0];
      nq_nxt[k]  = {nq_in[DV_Q_W-2:0], ge};
      d_nxt[k]   = d_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DV_STAGES; k++) begin
      d_r[k]   <= d_nxt[k];
      rem_r[k] <= rem_nxt[k];
      nq_r[k]  <= nq_nxt[k];
    end
  end

  assign quot = nq_r[DV_STAGES-1];

endmodule

### hdl/slj_term.sv
// ----------------------------------------------------------------------------
// slj_term
// Pipelined 4*eps*(x^12 - x^6) for x in Q.32, result in Q16.16. Each
// multiply is split into partial products and summed in the next stage.
// ----------------------------------------------------------------------------
module slj_term (
  input  logic                                 clk,
  input  logic [slj_pkg::DV_Q_W-1:0]           x,
  input  logic [23:0]                          eps,
  input  logic                                 cap_in,
  output logic signed [slj_pkg::TERM_W-1:0]    term,
  output logic                                 cap
);
  import slj_pkg::*;

  localparam int unsigned EPS_N = 9;
  localparam int unsigned CAP_N = 11;

  logic [53:0]  r1_pl_r, r1_ph_r;
  logic [35:0]  r1_x_r;
  logic [39:0]  r2_x2_r;
  logic [35:0]  r2_x_r;
  logic [57:0]  r3_pl_r, r3_ph_r;
  logic [43:0]  r4_x3_r;
  logic [65:0]  r5_pl_r, r5_ph_r;
  logic [55:0]  r6_q_r;
  logic [55:0]  r7_paa_r, r7_pab_r, r7_pbb_r, r7_q_r;
  logic [111:0] r8_s_r;
  logic [55:0]  r8_q_r;
  logic [111:0] r9_mag_r;
  logic         r9_neg_r;
  logic [47:0]  r10_h0_r, r10_h1_r;
  logic [55:0]  r10_l0_r, r10_l1_r;
  logic         r10_neg_r;
  logic [71:0]  r11_h_r;
  logic [87:0]  r11_lo_r;
  logic         r11_neg_r;
  logic signed [TERM_W-1:0] r12_term_r;
  logic         r12_cap_r;
  logic [23:0]  eps_r [EPS_N];
  logic         cap_r [CAP_N];

  logic [71:0]  sum2;
  logic [75:0]  sum4;
  logic [87:0]  sum6;
  logic [111:0] qs;
  logic         neg9;
  logic         capc;
  logic [51:0]  val;

  always_comb begin
    sum2 = {r1_ph_r, 18'b0} + 72'(r1_pl_r);
    sum4 = {r3_ph_r, 18'b0} + 76'(r3_pl_r);
    sum6 = {r5_ph_r, 22'b0} + 88'(r5_pl_r);
    qs   = {24'b0, r8_q_r, 32'b0};
    neg9 = (r8_s_r < qs);
    // below the cap h is at most 2^48, so the shifted value fits
    capc = (r11_h_r > 72'(64'h1_0000_0000_0000));
    val  = {r11_h_r[49:0], 2'b0} + 52'(r11_lo_r[87:62]);
  end

  always_ff @(posedge clk) begin
    r1_pl_r  <= 54'(x) * 54'(x[17:0]);
    r1_ph_r  <= 54'(x) * 54'(x[35:18]);
    r1_x_r   <= x;
    r2_x2_r  <= sum2[71:32];
    r2_x_r   <= r1_x_r;
    r3_pl_r  <= 58'(r2_x2_r) * 58'(r2_x_r[17:0]);
    r3_ph_r  <= 58'(r2_x2_r) * 58'(r2_x_r[35:18]);
    r4_x3_r  <= sum4[75:32];
    r5_pl_r  <= 66'(r4_x3_r) * 66'(r4_x3_r[21:0]);
    r5_ph_r  <= 66'(r4_x3_r) * 66'(r4_x3_r[43:22]);
    r6_q_r   <= sum6[87:32];
    r7_paa_r <= 56'(r6_q_r[55:28]) * 56'(r6_q_r[55:28]);
    r7_pab_r <= 56'(r6_q_r[55:28]) * 56'(r6_q_r[27:0]);
    r7_pbb_r <= 56'(r6_q_r[27:0]) * 56'(r6_q_r[27:0]);
    r7_q_r   <= r6_q_r;
    r8_s_r   <= {r7_paa_r, 56'b0} + 112'({r7_pab_r, 29'b0}) + 112'(r7_pbb_r);
    r8_q_r   <= r7_q_r;
    r9_mag_r <= neg9 ? (qs - r8_s_r) : (r8_s_r - qs);
    r9_neg_r <= neg9;
    r10_h0_r <= 48'(eps_r[EPS_N-1]) * 48'(r9_mag_r[87:64]);
    r10_h1_r <= 48'(eps_r[EPS_N-1]) * 48'(r9_mag_r[111:88]);
    r10_l0_r <= 56'(eps_r[EPS_N-1]) * 56'(r9_mag_r[31:0]);
    r10_l1_r <= 56'(eps_r[EPS_N-1]) * 56'(r9_mag_r[63:32]);
    r10_neg_r <= r9_neg_r;
    r11_h_r  <= 72'(r10_h0_r) + {r10_h1_r, 24'b0};
    r11_lo_r <= 88'(r10_l0_r) + {r10_l1_r, 32'b0};
    r11_neg_r <= r10_neg_r;
    r12_term_r <= r11_neg_r ? -$signed({1'b0, val}) : $signed({1'b0, val});
    r12_cap_r  <= cap_r[CAP_N-1] | capc;
    eps_r[0] <= eps;
    cap_r[0] <= cap_in;
    for (int k = 1; k < EPS_N; k++) eps_r[k] <= eps_r[k-1];
    for (int k = 1; k < CAP_N; k++) cap_r[k] <= cap_r[k-1];
  end

  assign term = r12_term_r;
  assign cap  = r12_cap_r;

endmodule

### hdl/shifted_lj_pair_energy.sv
// ----------------------------------------------------------------------------
// shifted_lj_pair_energy
// Shifted truncated Lennard-Jones / WCA half pair energy, fully pipelined.
//
//   channel   ports                               transaction when
//   input     start, busy, in_data                start & !busy
//   result    out_valid, out_data                 out_valid (one cycle)
//   config    cfg_valid, cfg_ready, cfg_index,    cfg_valid & cfg_ready
//             cfg_data
//
// One pair enters per cycle while busy is low; a result leaves after the
// front stages, 31-stage square root, 36-stage dividers and term units.
// busy is high in reset and the cycle after; the pipeline never stalls.
// Reset clears valid bits, sets busy, loads cfg defaults; data not reset.
// ----------------------------------------------------------------------------
module shifted_lj_pair_energy (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  slj_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  output slj_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [slj_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slj_pkg::CFG_W-1:0]          cfg_data
);
  import slj_pkg::*;

  typedef struct packed {
    logic               far;
    logic               kind;
    logic [23:0]        eps;
    logic signed [25:0] del;
    logic [29:0]        cut;
  } sa_t;

  typedef struct packed {
    logic        in_cut;
    logic        core;
    logic        kind;
    logic        gact;
    logic        xcap;
    logic        gcap;
    logic [23:0] eps;
  } sb_t;

  typedef struct packed {
    logic        in_cut;
    logic        core;
    logic        kind;
    logic        gact;
    logic [23:0] eps;
  } sc_t;

  function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {b[31], b} - {a[31], a};
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  logic             busy_r;
  logic [CFG_W-1:0] cf_r, shc_r;

  // stage 1
  logic        v1_r;
  logic [29:0] s1_adx_r, s1_ady_r, s1_adz_r;
  logic        s1_far_r, s1_kind_r;
  logic [23:0] s1_hs_r, s1_eps_r;
  // stage 2
  logic        v2_r;
  logic [59:0] s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic signed [25:0] s2_del_r;
  logic [21:0] s2_kshc_r;
  logic        s2_far_r, s2_kind_r;
  logic [23:0] s2_eps_r;
  // stage 3
  logic        v3_r;
  logic [SQ_IN_W-1:0] s3_sum_r;
  logic [24:0] s3_cut0_r;
  logic signed [25:0] s3_del_r;
  logic        s3_far_r, s3_kind_r;
  logic [23:0] s3_eps_r;
  // stage 4
  logic        v4_r;
  logic [SQ_IN_W-1:0] s4_sum_r;
  sa_t         s4_side_r;
  // stage 5
  logic        v5_r;
  logic [DV_D_W-1:0] s5_ud_r;
  sb_t         s5_side_r;
  // side lines
  logic [SQ_STAGES-1:0] vsq_r;
  logic [DV_STAGES-1:0] vdv_r;
  logic [TM_STAGES-1:0] vtm_r;
  sa_t sa_r [SQ_STAGES];
  sb_t sb_r [DV_STAGES];
  sc_t sc_r [TM_STAGES];
  // output
  logic       out_valid_r;
  out_item_t  out_data_r;

  logic [32:0] adx, ady, adz;
  logic [38:0] kprod;
  logic signed [26:0] c0;
  logic [45:0] cprod;
  logic [ROOT_W-1:0] root;
  sa_t         sa_end;
  logic signed [32:0] u;
  logic [DV_Q_W-1:0] qx, qg;
  logic signed [TERM_W-1:0] ta, tg;
  logic        capa, capg;
  sc_t         sc_end;
  logic signed [53:0] f;
  logic signed [52:0] hf;
  out_item_t   res_nxt;

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cf_r   <= CUTOFF_FACTOR_RST;
      shc_r  <= SHIFT_CORE_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CUTOFF_FACTOR: cf_r  <= cfg_data;
          CFG_SHIFT_CORE:    shc_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    adx   = abs_diff(in_data.pos_a_x, in_data.pos_b_x);
    ady   = abs_diff(in_data.pos_a_y, in_data.pos_b_y);
    adz   = abs_diff(in_data.pos_a_z, in_data.pos_b_z);
    kprod = 39'(shc_r) * 39'(K_Q16) + 39'(32768);
    c0    = $signed({s2_del_r[25], s2_del_r}) + $signed({5'b0, s2_kshc_r});
    cprod = 46'(s3_cut0_r) * 46'(cf_r);
  end

  // front stages: differences, squares, shift and cutoff
  always_ff @(posedge clk) begin
    s1_adx_r  <= adx[29:0];
    s1_ady_r  <= ady[29:0];
    s1_adz_r  <= adz[29:0];
    s1_far_r  <= (|adx[32:30]) | (|ady[32:30]) | (|adz[32:30]);
    s1_hs_r   <= 24'(({1'b0, in_data.diam_a} + {1'b0, in_data.diam_b}) >> 1);
    s1_eps_r  <= in_data.well_depth;
    s1_kind_r <= in_data.pair_kind;

    s2_sqx_r  <= 60'(s1_adx_r) * 60'(s1_adx_r);
    s2_sqy_r  <= 60'(s1_ady_r) * 60'(s1_ady_r);
    s2_sqz_r  <= 60'(s1_adz_r) * 60'(s1_adz_r);
    s2_del_r  <= $signed({2'b0, s1_hs_r}) - $signed({5'b0, shc_r});
    s2_kshc_r <= kprod[37:16];
    s2_far_r  <= s1_far_r;
    s2_kind_r <= s1_kind_r;
    s2_eps_r  <= s1_eps_r;

    s3_sum_r  <= 62'(s2_sqx_r) + 62'(s2_sqy_r) + 62'(s2_sqz_r);
    s3_cut0_r <= c0[26] ? 25'd0 : c0[24:0];
    s3_del_r  <= s2_del_r;
    s3_far_r  <= s2_far_r;
    s3_kind_r <= s2_kind_r;
    s3_eps_r  <= s2_eps_r;

    s4_sum_r       <= s3_sum_r;
    s4_side_r.far  <= s3_far_r;
    s4_side_r.kind <= s3_kind_r;
    s4_side_r.eps  <= s3_eps_r;
    s4_side_r.del  <= s3_del_r;
    s4_side_r.cut  <= s3_kind_r ? cprod[45:16] : {5'b0, s3_cut0_r};
  end

  slj_sqrt u_sqrt (
    .clk  (clk),
    .rad  (s4_sum_r),
    .root (root)
  );

  assign sa_end = sa_r[SQ_STAGES-1];
  assign u      = $signed({2'b0, root}) - $signed({{7{sa_end.del[25]}}, sa_end.del});

  always_ff @(posedge clk) begin
    s5_ud_r          <= u[31:0];
    s5_side_r.in_cut <= !sa_end.far && ({1'b0, sa_end.cut} > root);
    s5_side_r.core   <= u[32] || (u == '0);
    s5_side_r.kind   <= sa_end.kind;
    s5_side_r.gact   <= sa_end.kind && (cf_r != '0);
    // quotient reaches 2^36 exactly when shc >= 16*u
    s5_side_r.xcap   <= (36'(shc_r) >= {u[31:0], 4'b0});
    s5_side_r.gcap   <= (cf_r <= CFG_W'(G_REM0));
    s5_side_r.eps    <= sa_end.eps;
  end

  slj_div u_div_x (
    .clk      (clk),
    .divisor  (s5_ud_r),
    .rem_init (DV_D_W'(shc_r >> 4)),
    .num      ({shc_r[3:0], 32'b0}),
    .quot     (qx)
  );

  slj_div u_div_g (
    .clk      (clk),
    .divisor  (DV_D_W'(cf_r)),
    .rem_init (G_REM0),
    .num      ('0),
    .quot     (qg)
  );

  slj_term u_term_x (
    .clk    (clk),
    .x      (qx),
    .eps    (sb_r[DV_STAGES-1].eps),
    .cap_in (sb_r[DV_STAGES-1].xcap),
    .term   (ta),
    .cap    (capa)
  );

  slj_term u_term_g (
    .clk    (clk),
    .x      (qg),
    .eps    (sb_r[DV_STAGES-1].eps),
    .cap_in (sb_r[DV_STAGES-1].gcap),
    .term   (tg),
    .cap    (capg)
  );

  // side data travels beside the long units
  always_ff @(posedge clk) begin
    sa_r[0] <= s4_side_r;
    sb_r[0] <= s5_side_r;
    sc_r[0].in_cut <= sb_r[DV_STAGES-1].in_cut;
    sc_r[0].core   <= sb_r[DV_STAGES-1].core;
    sc_r[0].kind   <= sb_r[DV_STAGES-1].kind;
    sc_r[0].gact   <= sb_r[DV_STAGES-1].gact;
    sc_r[0].eps    <= sb_r[DV_STAGES-1].eps;
    for (int k = 1; k < SQ_STAGES; k++) sa_r[k] <= sa_r[k-1];
    for (int k = 1; k < DV_STAGES; k++) sb_r[k] <= sb_r[k-1];
    for (int k = 1; k < TM_STAGES; k++) sc_r[k] <= sc_r[k-1];
  end

  assign sc_end = sc_r[TM_STAGES-1];

  always_comb begin
    if (sc_end.kind)
      f = 54'(ta) - (sc_end.gact ? 54'(tg) : 54'sd0);
    else
      f = 54'(ta) + $signed({30'b0, sc_end.eps});
    hf = f[53:1];
    res_nxt = '{half_energy: '0, within_cutoff: sc_end.in_cut, saturated: 1'b0};
    if (!sc_end.in_cut) begin
      res_nxt.within_cutoff = 1'b0;
    end else if (sc_end.core) begin
      res_nxt.half_energy = OUT_MAX;
      res_nxt.saturated   = 1'b1;
    end else if (sc_end.eps == '0) begin
      res_nxt.half_energy = '0;
    end else if (capa) begin
      res_nxt.half_energy = OUT_MAX;
      res_nxt.saturated   = 1'b1;
    end else if (sc_end.gact && capg) begin
      res_nxt.half_energy = OUT_MIN;
      res_nxt.saturated   = 1'b1;
    end else if ((hf[52:47] != 6'b000000) && (hf[52:47] != 6'b111111)) begin
      res_nxt.half_energy = hf[52] ? OUT_MIN : OUT_MAX;
      res_nxt.saturated   = 1'b1;
    end else begin
      res_nxt.half_energy = hf[47:0];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= res_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vsq_r <= '0;
      vdv_r <= '0;
      vtm_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= start && !busy_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vsq_r <= {vsq_r[SQ_STAGES-2:0], v4_r};
      v5_r <= vsq_r[SQ_STAGES-1];
      vdv_r <= {vdv_r[DV_STAGES-2:0], v5_r};
      vtm_r <= {vtm_r[TM_STAGES-2:0], vdv_r[DV_STAGES-1]};
      out_valid_r <= vtm_r[TM_STAGES-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(SLJ_LATENCY) out_valid)
    else $error("accepted pair did not produce a result on time");

  a_sat_within: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.within_cutoff)
    else $error("saturated result outside cutoff");

  a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.within_cutoff |-> out_data.half_energy == '0)
    else $error("nonzero energy outside cutoff");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.half_energy == OUT_MAX || out_data.half_energy == OUT_MIN)
    else $error("saturated result not at a rail");

endmodule
